/* rtl/core/srbar_pkg.sv */
package srbar_pkg;

   // Width of the bar counter, enough for up to fifteen bar slots.
   localparam int CountWidth = 4;

   // Input commands.
   localparam logic CmdTick  = 1'b0;
   localparam logic CmdQuery = 1'b1;

   // Register indexes of the control and status port.
   localparam logic [1:0] CsrFirstPause    = 2'd0;
   localparam logic [1:0] CsrNextPause     = 2'd1;
   localparam logic [1:0] CsrStartPosition = 2'd2;

   // Register values after reset.
   localparam logic [7:0] FirstPauseReset    = 8'd200;
   localparam logic [7:0] NextPauseReset     = 8'd20;
   localparam logic [7:0] StartPositionReset = 8'd160;

   // Palette values when no bar covers the line.
   localparam logic [7:0] DefaultColourA = 8'h00;
   localparam logic [7:0] DefaultColourB = 8'h20;
   localparam logic [7:0] DefaultColourC = 8'h40;
   localparam logic [7:0] DefaultColourD = 8'h60;

   // Offset from region line to screen scanline.
   localparam logic [6:0] ScreenOffset = 7'd32;

   // Largest bar half height.
   localparam int MaxHalf = 8;

   typedef logic [6:0] sine_type;
   typedef logic [7:0] colour_type;

   // Control from the input stage to the bar state.
   typedef struct packed {
      logic       tick;
      logic       csr_write;
      logic [1:0] csr_index;
      logic [7:0] csr_data;
   } bar_ctl_type;

   // Top line of a bar for each phase.
   localparam sine_type SINE_ROM [256] = '{
      7'd63, 7'd64, 7'd65, 7'd65, 7'd66, 7'd67, 7'd68, 7'd68,
      7'd69, 7'd70, 7'd70, 7'd71, 7'd72, 7'd72, 7'd73, 7'd73,
      7'd74, 7'd74, 7'd75, 7'd75, 7'd76, 7'd76, 7'd77, 7'd77,
      7'd77, 7'd78, 7'd78, 7'd78, 7'd79, 7'd79, 7'd79, 7'd79,
      7'd79, 7'd80, 7'd80, 7'd80, 7'd80, 7'd80, 7'd80, 7'd80,
      7'd80, 7'd80, 7'd80, 7'd80, 7'd80, 7'd80, 7'd79, 7'd79,
      7'd79, 7'd79, 7'd79, 7'd78, 7'd78, 7'd78, 7'd77, 7'd77,
      7'd77, 7'd76, 7'd76, 7'd75, 7'd75, 7'd74, 7'd74, 7'd73,
      7'd73, 7'd72, 7'd72, 7'd71, 7'd70, 7'd70, 7'd69, 7'd68,
      7'd68, 7'd67, 7'd66, 7'd65, 7'd65, 7'd64, 7'd63, 7'd62,
      7'd61, 7'd61, 7'd60, 7'd59, 7'd58, 7'd57, 7'd56, 7'd55,
      7'd54, 7'd53, 7'd53, 7'd52, 7'd51, 7'd50, 7'd49, 7'd48,
      7'd47, 7'd46, 7'd45, 7'd44, 7'd43, 7'd42, 7'd41, 7'd40,
      7'd39, 7'd38, 7'd37, 7'd36, 7'd35, 7'd34, 7'd33, 7'd32,
      7'd31, 7'd30, 7'd29, 7'd28, 7'd27, 7'd27, 7'd26, 7'd25,
      7'd24, 7'd23, 7'd22, 7'd21, 7'd20, 7'd19, 7'd19, 7'd18,
      7'd17, 7'd16, 7'd15, 7'd15, 7'd14, 7'd13, 7'd12, 7'd12,
      7'd11, 7'd10, 7'd10, 7'd9,  7'd8,  7'd8,  7'd7,  7'd7,
      7'd6,  7'd6,  7'd5,  7'd5,  7'd4,  7'd4,  7'd3,  7'd3,
      7'd3,  7'd2,  7'd2,  7'd2,  7'd1,  7'd1,  7'd1,  7'd1,
      7'd1,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,
      7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd1,  7'd1,
      7'd1,  7'd1,  7'd1,  7'd2,  7'd2,  7'd2,  7'd3,  7'd3,
      7'd3,  7'd4,  7'd4,  7'd5,  7'd5,  7'd6,  7'd6,  7'd7,
      7'd7,  7'd8,  7'd8,  7'd9,  7'd10, 7'd10, 7'd11, 7'd12,
      7'd12, 7'd13, 7'd14, 7'd15, 7'd15, 7'd16, 7'd17, 7'd18,
      7'd19, 7'd19, 7'd20, 7'd21, 7'd22, 7'd23, 7'd24, 7'd25,
      7'd26, 7'd27, 7'd27, 7'd28, 7'd29, 7'd30, 7'd31, 7'd32,
      7'd33, 7'd34, 7'd35, 7'd36, 7'd37, 7'd38, 7'd39, 7'd40,
      7'd41, 7'd42, 7'd43, 7'd44, 7'd45, 7'd46, 7'd47, 7'd48,
      7'd49, 7'd50, 7'd51, 7'd52, 7'd53, 7'd53, 7'd54, 7'd55,
      7'd56, 7'd57, 7'd58, 7'd59, 7'd60, 7'd61, 7'd61, 7'd62
   };

   // Colour ramp from the bar edge toward its middle.
   localparam colour_type RAMP_ROM [8] = '{
      8'd32, 8'd64, 8'd96, 8'd128, 8'd160, 8'd192, 8'd224, 8'd232
   };

endpackage

/* rtl/core/srbar_bar_state.sv */
module srbar_bar_state
   import srbar_pkg::*;
#(
   parameter int BAR_SLOTS = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bar_ctl_type           ctl,
   output logic [CountWidth-1:0] active_bars,
   output logic [7:0]            bar_phase [BAR_SLOTS]
);

   logic [7:0]            first_pause_ff, first_pause_in;
   logic [7:0]            next_pause_ff, next_pause_in;
   logic [7:0]            start_position_ff, start_position_in;
   logic [7:0]            pause_left_ff, pause_left_in;
   logic [CountWidth-1:0] active_bars_ff, active_bars_in;
   logic [7:0]            bar_phase_ff [BAR_SLOTS];
   logic [7:0]            bar_phase_in [BAR_SLOTS];
   logic                  add_bar;

   always_comb begin
      first_pause_in    = first_pause_ff;
      next_pause_in     = next_pause_ff;
      start_position_in = start_position_ff;
      pause_left_in     = pause_left_ff;
      active_bars_in    = active_bars_ff;
      bar_phase_in      = bar_phase_ff;
      add_bar           = 1'b0;
      if (ctl.tick) begin
         if (pause_left_ff == 8'd0) begin
            pause_left_in = next_pause_ff;
            add_bar = (active_bars_ff < CountWidth'(BAR_SLOTS));
         end else begin
            pause_left_in = pause_left_ff - 8'd1;
         end
         if (add_bar) begin
            active_bars_in = active_bars_ff + CountWidth'(1);
         end
         // A fresh bar is stepped in the same tick it enters.
         for (int i = 0; i < BAR_SLOTS; i++) begin
            if (CountWidth'(i) < active_bars_ff) begin
               bar_phase_in[i] = bar_phase_ff[i] + 8'd1;
            end else if (add_bar && CountWidth'(i) == active_bars_ff) begin
               bar_phase_in[i] = start_position_ff + 8'd1;
            end
         end
      end else if (ctl.csr_write) begin
         case (ctl.csr_index)
            CsrFirstPause: begin
               first_pause_in = ctl.csr_data;
               // Before any bar has entered the countdown restarts from it.
               if (active_bars_ff == '0) begin
                  pause_left_in = ctl.csr_data;
               end
            end
            CsrNextPause: begin
               next_pause_in = ctl.csr_data;
            end
            CsrStartPosition: begin
               start_position_in = ctl.csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_pause_ff    <= FirstPauseReset;
         next_pause_ff     <= NextPauseReset;
         start_position_ff <= StartPositionReset;
         pause_left_ff     <= FirstPauseReset;
         active_bars_ff    <= '0;
      end else begin
         first_pause_ff    <= first_pause_in;
         next_pause_ff     <= next_pause_in;
         start_position_ff <= start_position_in;
         pause_left_ff     <= pause_left_in;
         active_bars_ff    <= active_bars_in;
      end
   end

   always_ff @(posedge clock) begin
      bar_phase_ff <= bar_phase_in;
   end

   assign active_bars = active_bars_ff;
   assign bar_phase   = bar_phase_ff;

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      active_bars_ff <= CountWidth'(BAR_SLOTS))
      else $error("bar count beyond slot count");

   assert property (@(posedge clock) disable iff (reset)
      ctl.tick && pause_left_ff != 8'd0 |=> pause_left_ff == $past(pause_left_ff) - 8'd1)
      else $error("pause did not count down on tick");

   assert property (@(posedge clock) disable iff (reset)
      !ctl.tick |=> active_bars_ff == $past(active_bars_ff))
      else $error("bar count changed without a tick");
`endif

endmodule

/* rtl/core/srbar_line_colour.sv */
module srbar_line_colour
   import srbar_pkg::*;
#(
   parameter int BAR_SLOTS = 10
) (
   input  logic [CountWidth-1:0] active_bars,
   input  logic [7:0]            bar_phase [BAR_SLOTS],
   input  logic [6:0]            line_index,
   output logic                  hit,
   output colour_type            colour
);

   logic [7:0] line_ext;
   logic [7:0] top;
   logic [4:0] half;
   logic [3:0] k;
   logic       covers;

   // Every bar is checked in parallel; the lowest-numbered covering bar wins,
   // so the scan runs from the highest slot down and later matches override.
   always_comb begin
      line_ext = {1'b0, line_index};
      hit      = 1'b0;
      colour   = RAMP_ROM[0];
      top      = '0;
      half     = '0;
      k        = '0;
      covers   = 1'b0;
      for (int i = BAR_SLOTS - 1; i >= 0; i--) begin
         top    = {1'b0, SINE_ROM[bar_phase[i]]};
         half   = 5'(MaxHalf - (i >> 1));
         covers = (CountWidth'(i) < active_bars) && (line_ext >= top)
                  && (line_ext < top + {2'b00, half, 1'b0});
         k = 4'(line_ext - top);
         if ({1'b0, k} >= half) begin
            k = 4'({half, 1'b0} - 6'd1 - {2'b00, k});
         end
         if (covers) begin
            hit    = 1'b1;
            colour = RAMP_ROM[k[2:0]];
         end
      end
   end

endmodule

/* rtl/core/sine_raster_bar_line_colour.sv */
// An accepted query beat moves from the input register to the result register,
// which drives the rsp_ outputs.
// Throughput: one beat per cycle, ticks and queries alike, while no result is held; ticks give no result.
// A result held by the receiver keeps the next query in the input register.
// Reset is synchronous and active high: registers return to their reset
// values, no bars are active and the pause counter loads the first pause.
module sine_raster_bar_line_colour
   import srbar_pkg::*;
#(
   parameter int BAR_SLOTS = 10
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_command,
   input  logic [6:0] req_line_index,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [6:0] rsp_screen_line,
   output logic       rsp_bar_hit,
   output logic [7:0] rsp_colour_a,
   output logic [7:0] rsp_colour_b,
   output logic [7:0] rsp_colour_c,
   output logic [7:0] rsp_colour_d,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data
);

   // The input register holds one beat. A tick updates the bar state when it
   // leaves the input register, so a query right behind it sees the new bars.
   // A query leaves only when the result register is free or being emptied.
   // Register writes are taken only while the input register is empty, so a
   // write never meets a tick at the same edge.
   logic       stage_valid_ff, stage_valid_in;
   logic       stage_command_ff;
   logic [6:0] stage_line_ff;
   logic       stage_go;
   logic       stage_query;
   logic       rsp_free;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [6:0] rsp_screen_line_ff;
   logic       rsp_bar_hit_ff;
   colour_type rsp_colour_a_ff, rsp_colour_b_ff, rsp_colour_c_ff, rsp_colour_d_ff;

   bar_ctl_type           bar_ctl;
   logic [CountWidth-1:0] active_bars;
   logic [7:0]            bar_phase [BAR_SLOTS];
   logic                  line_hit;
   colour_type            line_colour;

   assign rsp_free    = !rsp_valid_ff || rsp_ready;
   assign stage_query = stage_valid_ff && (stage_command_ff == CmdQuery);
   assign stage_go    = stage_valid_ff && ((stage_command_ff == CmdTick) || rsp_free);
   assign req_ready   = !stage_valid_ff || stage_go;
   assign csr_ready   = !stage_valid_ff;

   always_comb begin
      bar_ctl.tick      = stage_go && (stage_command_ff == CmdTick);
      bar_ctl.csr_write = csr_valid && csr_ready;
      bar_ctl.csr_index = csr_index;
      bar_ctl.csr_data  = csr_data;
   end

   srbar_bar_state #(
      .BAR_SLOTS(BAR_SLOTS)
   ) u_bar_state (
      .clock      (clock),
      .reset      (reset),
      .ctl        (bar_ctl),
      .active_bars(active_bars),
      .bar_phase  (bar_phase)
   );

   srbar_line_colour #(
      .BAR_SLOTS(BAR_SLOTS)
   ) u_line_colour (
      .active_bars(active_bars),
      .bar_phase  (bar_phase),
      .line_index (stage_line_ff),
      .hit        (line_hit),
      .colour     (line_colour)
   );

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_valid && req_ready) begin
         stage_valid_in = 1'b1;
      end else if (stage_go) begin
         stage_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (stage_go && stage_query) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stage_command_ff <= req_command;
         stage_line_ff    <= req_line_index;
      end
      if (stage_go && stage_query) begin
         rsp_screen_line_ff <= stage_line_ff + ScreenOffset;
         rsp_bar_hit_ff     <= line_hit;
         if (line_hit) begin
            rsp_colour_a_ff <= line_colour;
            rsp_colour_b_ff <= line_colour;
            rsp_colour_c_ff <= line_colour;
            rsp_colour_d_ff <= line_colour;
         end else begin
            rsp_colour_a_ff <= DefaultColourA;
            rsp_colour_b_ff <= DefaultColourB;
            rsp_colour_c_ff <= DefaultColourC;
            rsp_colour_d_ff <= DefaultColourD;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_screen_line = rsp_screen_line_ff;
   assign rsp_bar_hit     = rsp_bar_hit_ff;
   assign rsp_colour_a    = rsp_colour_a_ff;
   assign rsp_colour_b    = rsp_colour_b_ff;
   assign rsp_colour_c    = rsp_colour_c_ff;
   assign rsp_colour_d    = rsp_colour_d_ff;

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> stage_valid_ff && stage_query && rsp_valid_ff && !rsp_ready)
      else $error("input stalled without a blocked query");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(stage_query))
      else $error("result raised without a query in the input register");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_bar_hit_ff |-> rsp_colour_a_ff == rsp_colour_d_ff)
      else $error("bar colour not repeated across the palette values");
`endif

endmodule
